>>> hdl/csrc_pkg.sv
`timescale 1ns / 1ps
package csrc_pkg;

  localparam int unsigned MaxRes = 8;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);
  localparam int unsigned IdxW   = $clog2(MaxRes);

  // comment stage modes
  localparam logic [2:0] MODE_TEXT  = 3'd0;
  localparam logic [2:0] MODE_SLASH = 3'd1;
  localparam logic [2:0] MODE_LINE  = 3'd2;
  localparam logic [2:0] MODE_BLOCK = 3'd3;
  localparam logic [2:0] MODE_STAR  = 3'd4;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  typedef struct packed {
    logic [1:0] qcnt;
    logic       bslash;
    logic [2:0] mode;
    logic       has_content;
    logic       nl_pend;
  } st_t;

  typedef struct packed {
    st_t                     st;
    logic [CntW-1:0]         cnt;
    logic [MaxRes-1:0][7:0]  bytes;
  } res_t;

  function automatic res_t put_byte(res_t r, logic [7:0] b);
    res_t o;
    o = r;
    if (o.cnt < CntW'(MaxRes)) begin
      o.bytes[o.cnt[IdxW-1:0]] = b;
      o.cnt = o.cnt + CntW'(1);
    end
    return o;
  endfunction

  function automatic res_t put_content(res_t r, logic [7:0] b);
    res_t o;
    o = r;
    if (o.st.nl_pend) begin
      o = put_byte(o, CH_NL);
      o.st.nl_pend = 1'b0;
    end
    o = put_byte(o, b);
    o.st.has_content = 1'b1;
    return o;
  endfunction

  function automatic res_t put_plain(res_t r, logic [7:0] c);
    res_t o;
    o = r;
    if (c == CH_NL) begin
      if (o.st.has_content) begin
        o.st.has_content = 1'b0;
        o.st.nl_pend = 1'b1;
      end
    end else begin
      o = put_content(o, c);
    end
    return o;
  endfunction

  function automatic res_t comment_stage(res_t r, logic [7:0] c);
    res_t o;
    o = r;
    unique case (o.st.mode)
      MODE_SLASH: begin
        if (c == CH_SLASH) begin
          o.st.mode = MODE_LINE;
          o = put_content(o, CH_SP);
        end else if (c == CH_STAR) begin
          o.st.mode = MODE_BLOCK;
          o = put_content(o, CH_SP);
        end else begin
          o.st.mode = MODE_TEXT;
          o = put_content(o, CH_SLASH);
          o = put_plain(o, c);
        end
      end
      MODE_LINE: begin
        if (c == CH_NL) begin
          o.st.mode = MODE_TEXT;
          o = put_plain(o, c);
        end
      end
      MODE_BLOCK: begin
        if (c == CH_STAR) o.st.mode = MODE_STAR;
      end
      MODE_STAR: begin
        if (c == CH_SLASH) o.st.mode = MODE_TEXT;
        else if (c != CH_STAR) o.st.mode = MODE_BLOCK;
      end
      default: begin
        // unused codes behave as text mode
        if (c == CH_SLASH) begin
          o.st.mode = MODE_SLASH;
        end else begin
          o.st.mode = MODE_TEXT;
          o = put_plain(o, c);
        end
      end
    endcase
    return o;
  endfunction

  function automatic res_t splice_stage(res_t r, logic [7:0] c);
    res_t o;
    o = r;
    if (o.st.bslash) begin
      if (c == CH_NL) begin
        o.st.bslash = 1'b0;
      end else begin
        o = comment_stage(o, CH_BSL);
        if (c != CH_BSL) begin
          o.st.bslash = 1'b0;
          o = comment_stage(o, c);
        end
      end
    end else if (c == CH_BSL) begin
      o.st.bslash = 1'b1;
    end else begin
      o = comment_stage(o, c);
    end
    return o;
  endfunction

  // bit 8 flags a trigraph third character
  function automatic logic [8:0] trigraph_map(logic [7:0] c);
    logic [8:0] m;
    unique case (c)
      CH_EQ:    m = {1'b1, CH_HASH};
      CH_SLASH: m = {1'b1, CH_BSL};
      CH_QUOTE: m = {1'b1, CH_CARET};
      CH_LPAR:  m = {1'b1, CH_LBRK};
      CH_RPAR:  m = {1'b1, CH_RBRK};
      CH_BANG:  m = {1'b1, CH_BAR};
      CH_LT:    m = {1'b1, CH_LBRC};
      CH_GT:    m = {1'b1, CH_RBRC};
      CH_MINUS: m = {1'b1, CH_TILDE};
      default:  m = {1'b0, c};
    endcase
    return m;
  endfunction

  function automatic res_t flush_questions(res_t r);
    res_t o;
    o = r;
    for (int i = 0; i < 2; i++) begin
      if (o.st.qcnt != 2'd0) begin
        o = splice_stage(o, CH_QM);
        o.st.qcnt = o.st.qcnt - 2'd1;
      end
    end
    return o;
  endfunction

  function automatic res_t trigraph_stage(res_t r, logic [7:0] c);
    res_t       o;
    logic [8:0] m;
    o = r;
    m = trigraph_map(c);
    if (c == CH_QM) begin
      if (o.st.qcnt < 2'd2) o.st.qcnt = o.st.qcnt + 2'd1;
      else o = splice_stage(o, CH_QM);
    end else if (o.st.qcnt >= 2'd2 && m[8]) begin
      o.st.qcnt = 2'd0;
      o = splice_stage(o, m[7:0]);
    end else begin
      o = flush_questions(o);
      o = splice_stage(o, c);
    end
    return o;
  endfunction

  function automatic res_t flush_all(res_t r);
    res_t o;
    o = flush_questions(r);
    if (o.st.bslash) begin
      o.st.bslash = 1'b0;
      o = comment_stage(o, CH_BSL);
    end
    if (o.st.mode == MODE_SLASH) o = put_content(o, CH_SLASH);
    if (o.st.has_content || o.st.nl_pend) o = put_byte(o, CH_NL);
    return o;
  endfunction

  function automatic res_t step(st_t st, logic [7:0] c, logic fin);
    res_t o;
    o       = '0;
    o.st    = st;
    o       = trigraph_stage(o, c);
    if (fin) begin
      o    = flush_all(o);
      o.st = '0;
    end
    return o;
  endfunction

endpackage

>>> hdl/c_source_trigraph_splice_comment_strip.sv
`timescale 1ns / 1ps
// Cleans C source text (trigraph replacement, line splicing, comment removal,
// empty-line dropping) one byte per cycle unless stalled. Each accepted item
// is worked out in one pass and its zero to eight result bytes go into a
// result buffer that drains one byte per cycle while out_stall is low; a new
// item is taken in the cycle the buffer's last byte leaves, or at once while
// the buffer is empty. An item that yields no byte leaves the buffer empty;
// the final byte of a text resets all state for the next text.
module c_source_trigraph_splice_comment_strip (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_is_final,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_text_done
);

  localparam int unsigned CntW = csrc_pkg::CntW;
  localparam int unsigned IdxW = csrc_pkg::IdxW;

  csrc_pkg::st_t                         st_r;
  csrc_pkg::res_t                        res_nxt;
  logic [csrc_pkg::MaxRes-1:0][7:0]      buf_r;
  logic [CntW-1:0]                       num_r;
  logic [IdxW-1:0]                       rd_r;
  logic                                  fin_r;
  logic                                  last;
  logic                                  take;
  logic                                  accept;

  assign out_valid     = (num_r != '0);
  assign last          = ({1'b0, rd_r} == (num_r - CntW'(1)));
  assign out_byte      = buf_r[rd_r];
  assign out_run_last  = last;
  assign out_text_done = last & fin_r;
  assign take          = out_valid & ~out_stall;
  // buffer frees up in the cycle its last byte is taken
  assign in_stall      = out_valid & ~(take & last);
  assign accept        = in_valid & ~in_stall;

  always_comb begin
    res_nxt = csrc_pkg::step(st_r, in_byte, in_is_final);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      num_r <= '0;
      rd_r  <= '0;
      fin_r <= 1'b0;
    end else if (accept) begin
      st_r  <= res_nxt.st;
      num_r <= res_nxt.cnt;
      rd_r  <= '0;
      fin_r <= in_is_final;
    end else if (take) begin
      if (last) begin
        num_r <= '0;
        rd_r  <= '0;
      end else begin
        rd_r <= rd_r + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_r <= res_nxt.bytes;
    end
  end

endmodule
